[rtl/rgb_to_lab_pixel_convert_macros.svh]
// ---------------------------------------------------------------------------
// rgb_to_lab_pixel_convert_macros.svh
// Assertion macros shared by the pixel converter RTL.
// ---------------------------------------------------------------------------
`ifndef RGB_TO_LAB_PIXEL_CONVERT_MACROS_SVH
`define RGB_TO_LAB_PIXEL_CONVERT_MACROS_SVH

// cond at one edge implies expr at the next edge
`define RGBLAB_ASSERT_NEXT(name, cond, expr) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error("rgblab assertion failed");

// cond implies expr at the same edge
`define RGBLAB_ASSERT_NOW(name, cond, expr) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error("rgblab assertion failed");

`endif

[rtl/rgblab_pkg.sv]
// ---------------------------------------------------------------------------
// rgblab_pkg
// Shared constants for the RGB to CIELAB pixel converter.
// ---------------------------------------------------------------------------
`default_nettype none
package rgblab_pkg;

   localparam int LAT_MAT   = 3;
   localparam int LAT_RATIO = 19;
   localparam int LAT_LABF  = 17;
   localparam int LAT_OUT   = 2;
   localparam int LAT_TOTAL = LAT_MAT + LAT_RATIO + LAT_LABF + LAT_OUT;
   localparam int XYZ_DELAY = LAT_RATIO + LAT_LABF + LAT_OUT;

   localparam int CSR_AW = 4;

   localparam logic [1:0] CSR_WHITE_X = 2'd0;
   localparam logic [1:0] CSR_WHITE_Y = 2'd1;
   localparam logic [1:0] CSR_WHITE_Z = 2'd2;

   localparam logic [17:0] WHITE_X_RESET = 18'd95047;
   localparam logic [17:0] WHITE_Y_RESET = 18'd100000;
   localparam logic [17:0] WHITE_Z_RESET = 18'd108883;

   localparam logic [17:0] RATIO_MAX = 18'h3FFFF;
   localparam logic [17:0] F_THRESH  = 18'd581;

endpackage
`default_nettype wire

[rtl/rgb_to_lab_pixel_convert.sv]
// ---------------------------------------------------------------------------
// rgb_to_lab_pixel_convert
// RGB byte pixel to XYZ and CIELAB bytes, fully pipelined.
// ---------------------------------------------------------------------------
// Throughput: one word per cycle while the result side accepts; the ratio divider
// takes 19 stages (a range check, then one quotient bit per stage) and the cube root
// 17 stages (one bit per stage). A stall at the result side holds every stage in place.
// Reset clears the valid bits and loads the D65 white registers.
`default_nettype none
`include "rgb_to_lab_pixel_convert_macros.svh"
module rgb_to_lab_pixel_convert (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // red [7:0], green [15:8], blue [23:16]
   input  wire logic [23:0]                   req_tdata,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // x_value, y_value, z_value, lightness, green_red, blue_yellow, low byte up
   output logic      [47:0]                   rsp_tdata,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [rgblab_pkg::CSR_AW-1:0] csr_paddr,
   input  wire logic [31:0]                   csr_pwdata,
   output logic      [31:0]                   csr_prdata,
   output logic                               csr_pready
);

   localparam int LAT = rgblab_pkg::LAT_TOTAL;

   logic [17:0]    white_x_ff, white_y_ff, white_z_ff;
   logic [LAT-1:0] valid_ff;
   logic           ce;
   logic           csr_wr;
   logic [1:0]     csr_idx;
   logic [7:0]     xv, yv, zv;
   logic [17:0]    tx, ty, tz;
   logic [16:0]    fx, fy, fz;
   logic [7:0]     l_out, a_out, b_out;
   logic [23:0]    xyz_ff [rgblab_pkg::XYZ_DELAY];

   assign ce         = !valid_ff[LAT-1] || rsp_tready;
   assign req_tready = ce;
   assign rsp_tvalid = valid_ff[LAT-1];
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[3:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         white_x_ff <= rgblab_pkg::WHITE_X_RESET;
         white_y_ff <= rgblab_pkg::WHITE_Y_RESET;
         white_z_ff <= rgblab_pkg::WHITE_Z_RESET;
      end else if (csr_wr) begin
         unique case (csr_idx)
            rgblab_pkg::CSR_WHITE_X: white_x_ff <= csr_pwdata[17:0];
            rgblab_pkg::CSR_WHITE_Y: white_y_ff <= csr_pwdata[17:0];
            rgblab_pkg::CSR_WHITE_Z: white_z_ff <= csr_pwdata[17:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         rgblab_pkg::CSR_WHITE_X: csr_prdata = {14'd0, white_x_ff};
         rgblab_pkg::CSR_WHITE_Y: csr_prdata = {14'd0, white_y_ff};
         rgblab_pkg::CSR_WHITE_Z: csr_prdata = {14'd0, white_z_ff};
         default:                 csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ce) begin
         valid_ff <= {valid_ff[LAT-2:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         xyz_ff[0] <= {zv, yv, xv};
         for (int k = 1; k < rgblab_pkg::XYZ_DELAY; k++) begin
            xyz_ff[k] <= xyz_ff[k-1];
         end
      end
   end

   rgblab_matrix u_matrix (
      .clock   (clock),
      .ce      (ce),
      .red     (req_tdata[7:0]),
      .green   (req_tdata[15:8]),
      .blue    (req_tdata[23:16]),
      .x_value (xv),
      .y_value (yv),
      .z_value (zv)
   );

   rgblab_ratio u_ratio_x (.clock(clock), .ce(ce), .value(xv), .white(white_x_ff), .ratio(tx));
   rgblab_ratio u_ratio_y (.clock(clock), .ce(ce), .value(yv), .white(white_y_ff), .ratio(ty));
   rgblab_ratio u_ratio_z (.clock(clock), .ce(ce), .value(zv), .white(white_z_ff), .ratio(tz));

   rgblab_labf u_labf_x (.clock(clock), .ce(ce), .ratio(tx), .f_value(fx));
   rgblab_labf u_labf_y (.clock(clock), .ce(ce), .ratio(ty), .f_value(fy));
   rgblab_labf u_labf_z (.clock(clock), .ce(ce), .ratio(tz), .f_value(fz));

   rgblab_lab_out u_lab_out (
      .clock       (clock),
      .ce          (ce),
      .fx          (fx),
      .fy          (fy),
      .fz          (fz),
      .lightness   (l_out),
      .green_red   (a_out),
      .blue_yellow (b_out)
   );

   assign rsp_tdata = {b_out, a_out, l_out, xyz_ff[rgblab_pkg::XYZ_DELAY-1]};

   `RGBLAB_ASSERT_NEXT(a_stall_holds, !ce, $stable(valid_ff))
   `RGBLAB_ASSERT_NEXT(a_accept_enters, req_tvalid && req_tready, valid_ff[0])
   `RGBLAB_ASSERT_NEXT(a_fill_reaches_out, ce && valid_ff[LAT-2], rsp_tvalid)
   `RGBLAB_ASSERT_NEXT(a_csr_x_write, csr_wr && csr_idx == rgblab_pkg::CSR_WHITE_X, white_x_ff == $past(csr_pwdata[17:0]))
   `RGBLAB_ASSERT_NOW(a_ready_when_open, !rsp_tvalid, req_tready)

endmodule
`default_nettype wire

[rtl/rgblab_matrix.sv]
// ---------------------------------------------------------------------------
// rgblab_matrix
// Three-stage RGB to XYZ matrix with divide by one million and clamp.
// ---------------------------------------------------------------------------
`default_nettype none
module rgblab_matrix (
   input  wire logic       clock,
   input  wire logic       ce,
   input  wire logic [7:0] red,
   input  wire logic [7:0] green,
   input  wire logic [7:0] blue,
   output logic      [7:0] x_value,
   output logic      [7:0] y_value,
   output logic      [7:0] z_value
);

   localparam logic [19:0] C00 = 20'd412453;
   localparam logic [19:0] C01 = 20'd357580;
   localparam logic [19:0] C02 = 20'd180423;
   localparam logic [19:0] C10 = 20'd212671;
   localparam logic [19:0] C11 = 20'd715160;
   localparam logic [19:0] C12 = 20'd72169;
   localparam logic [19:0] C20 = 20'd19334;
   localparam logic [19:0] C21 = 20'd119193;
   localparam logic [19:0] C22 = 20'd950227;
   localparam logic [11:0] RECIP = 12'd2147;
   localparam logic [29:0] MEGA  = 30'd1000000;

   logic [28:0] sum_ff [3];
   logic [28:0] sum_in [3];
   logic [28:0] sum2_ff [3];
   logic [8:0]  qe_ff [3];
   logic [8:0]  qe_in [3];
   logic [7:0]  byte_ff [3];
   logic [7:0]  byte_in [3];

   always_comb begin
      sum_in[0] = 29'(red) * 29'(C00) + 29'(green) * 29'(C01) + 29'(blue) * 29'(C02);
      sum_in[1] = 29'(red) * 29'(C10) + 29'(green) * 29'(C11) + 29'(blue) * 29'(C12);
      sum_in[2] = 29'(red) * 29'(C20) + 29'(green) * 29'(C21) + 29'(blue) * 29'(C22);
   end

   always_comb begin
      logic [40:0] prod;
      logic [29:0] rem;
      logic [9:0]  q;
      for (int c = 0; c < 3; c++) begin
         prod = 41'(sum_ff[c]) * 41'(RECIP);
         qe_in[c] = prod[39:31];
      end
      for (int c = 0; c < 3; c++) begin
         rem = 30'(sum2_ff[c]) - 30'(qe_ff[c]) * MEGA;
         q = (rem >= MEGA) ? 10'(qe_ff[c]) + 10'd1 : 10'(qe_ff[c]);
         byte_in[c] = (q > 10'd255) ? 8'hFF : q[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         sum_ff  <= sum_in;
         sum2_ff <= sum_ff;
         qe_ff   <= qe_in;
         byte_ff <= byte_in;
      end
   end

   assign x_value = byte_ff[0];
   assign y_value = byte_ff[1];
   assign z_value = byte_ff[2];

endmodule
`default_nettype wire

[rtl/rgblab_ratio.sv]
// ---------------------------------------------------------------------------
// rgblab_ratio
// Pipelined restoring divider: byte * 65536000 / white, Q2.16, saturating.
// ---------------------------------------------------------------------------
`default_nettype none
module rgblab_ratio (
   input  wire logic        clock,
   input  wire logic        ce,
   input  wire logic [7:0]  value,
   input  wire logic [17:0] white,
   output logic      [17:0] ratio
);

   localparam logic [33:0] SCALE = 34'd65536000;

   logic [33:0] rem_ff [19];
   logic [17:0] quo_ff [19];
   logic        sat_ff [19];
   logic [33:0] n0_in;

   assign n0_in = 34'(value) * SCALE;

   always_ff @(posedge clock) begin
      if (ce) begin
         rem_ff[0] <= n0_in;
         quo_ff[0] <= '0;
         sat_ff[0] <= {2'b00, n0_in} >= {white, 18'd0};
      end
   end

   for (genvar k = 1; k < 19; k++) begin : g_bit
      localparam int B = 18 - k;
      logic [35:0] sh;
      logic        take;
      assign sh   = 36'(white) << B;
      assign take = {2'b00, rem_ff[k-1]} >= sh;
      always_ff @(posedge clock) begin
         if (ce) begin
            rem_ff[k] <= take ? rem_ff[k-1] - sh[33:0] : rem_ff[k-1];
            quo_ff[k] <= quo_ff[k-1] | (take ? (18'd1 << B) : 18'd0);
            sat_ff[k] <= sat_ff[k-1];
         end
      end
   end

   assign ratio = sat_ff[18] ? rgblab_pkg::RATIO_MAX : quo_ff[18];

endmodule
`default_nettype wire

[rtl/rgblab_labf.sv]
// ---------------------------------------------------------------------------
// rgblab_labf
// CIELAB f function: bit-serial pipelined cube root with a linear segment.
// ---------------------------------------------------------------------------
`default_nettype none
module rgblab_labf (
   input  wire logic        clock,
   input  wire logic        ce,
   input  wire logic [17:0] ratio,
   output logic      [16:0] f_value
);

   localparam logic [30:0] LIN_MUL   = 31'd903292;
   localparam logic [30:0] LIN_OFS   = 31'd1048576000;
   localparam logic [54:0] LIN_RECIP = 55'd9478362;
   localparam logic [31:0] LIN_DIV   = 32'd116000;

   logic [16:0] res_ff [17];
   logic [33:0] sq_ff  [17];
   logic [52:0] cu_ff  [17];
   logic [17:0] t_ff   [17];
   logic [30:0] lnum_ff;
   logic [30:0] lnum1_ff;
   logic [14:0] lest_ff;
   logic [16:0] lin_ff [2:16];

   for (genvar k = 0; k < 17; k++) begin : g_root
      localparam int B = 16 - k;
      logic [16:0] res_p;
      logic [33:0] sq_p;
      logic [52:0] cu_p;
      logic [17:0] t_p;
      logic [52:0] cube_c;
      logic [52:0] target;
      logic        take;
      if (k == 0) begin : g_first
         assign res_p = '0;
         assign sq_p  = '0;
         assign cu_p  = '0;
         assign t_p   = ratio;
      end else begin : g_rest
         assign res_p = res_ff[k-1];
         assign sq_p  = sq_ff[k-1];
         assign cu_p  = cu_ff[k-1];
         assign t_p   = t_ff[k-1];
      end
      assign cube_c = cu_p + ((53'(sq_p) << B) + (53'(sq_p) << (B + 1)))
                    + ((53'(res_p) << (2 * B)) + (53'(res_p) << (2 * B + 1)))
                    + (53'd1 << (3 * B));
      assign target = {3'b000, t_p, 32'd0};
      assign take   = cube_c <= target;
      always_ff @(posedge clock) begin
         if (ce) begin
            t_ff[k] <= t_p;
            if (take) begin
               res_ff[k] <= res_p | (17'd1 << B);
               sq_ff[k]  <= 34'(36'(sq_p) + (36'(res_p) << (B + 1)) + (36'd1 << (2 * B)));
               cu_ff[k]  <= cube_c;
            end else begin
               res_ff[k] <= res_p;
               sq_ff[k]  <= sq_p;
               cu_ff[k]  <= cu_p;
            end
         end
      end
   end

   logic [54:0] lprod;
   logic [31:0] lrem;
   logic [16:0] lin_in;

   assign lprod  = 55'(lnum_ff) * LIN_RECIP;
   assign lrem   = 32'(lnum1_ff) - 32'(lest_ff) * LIN_DIV;
   assign lin_in = (lrem >= LIN_DIV) ? 17'(lest_ff) + 17'd1 : 17'(lest_ff);

   always_ff @(posedge clock) begin
      if (ce) begin
         lnum_ff  <= 31'(ratio[9:0]) * LIN_MUL + LIN_OFS;
         lnum1_ff <= lnum_ff;
         lest_ff  <= lprod[54:40];
         lin_ff[2] <= lin_in;
         for (int k = 3; k < 17; k++) begin
            lin_ff[k] <= lin_ff[k-1];
         end
      end
   end

   assign f_value = (t_ff[16] >= rgblab_pkg::F_THRESH) ? res_ff[16] : lin_ff[16];

endmodule
`default_nettype wire

[rtl/rgblab_lab_out.sv]
// ---------------------------------------------------------------------------
// rgblab_lab_out
// Form L, a and b from the f values: scale, truncate toward zero, clamp.
// ---------------------------------------------------------------------------
`default_nettype none
module rgblab_lab_out (
   input  wire logic        clock,
   input  wire logic        ce,
   input  wire logic [16:0] fx,
   input  wire logic [16:0] fy,
   input  wire logic [16:0] fz,
   output logic      [7:0]  lightness,
   output logic      [7:0]  green_red,
   output logic      [7:0]  blue_yellow
);

   logic signed [31:0] l_ff, a_ff, b_ff;
   logic        [7:0]  lo_ff, ao_ff, bo_ff;

   function automatic logic signed [31:0] tdiv16(input logic signed [31:0] v);
      logic signed [31:0] neg;
      neg = -v;
      if (v < 0) begin
         return -(neg >>> 16);
      end
      return v >>> 16;
   endfunction

   function automatic logic [7:0] clamp8(input logic signed [31:0] v);
      if (v < 0) begin
         return 8'd0;
      end
      if (v > 32'sd255) begin
         return 8'hFF;
      end
      return v[7:0];
   endfunction

   always_ff @(posedge clock) begin
      if (ce) begin
         l_ff  <= 32'sd116 * $signed({15'd0, fy}) - 32'sd1048576;
         a_ff  <= 32'sd500 * ($signed({15'd0, fx}) - $signed({15'd0, fy}));
         b_ff  <= 32'sd200 * ($signed({15'd0, fy}) - $signed({15'd0, fz}));
         lo_ff <= clamp8(tdiv16(l_ff));
         ao_ff <= clamp8(tdiv16(a_ff) + 32'sd128);
         bo_ff <= clamp8(tdiv16(b_ff) + 32'sd128);
      end
   end

   assign lightness   = lo_ff;
   assign green_red   = ao_ff;
   assign blue_yellow = bo_ff;

endmodule
`default_nettype wire
